>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL module of the factor product expander.
// Each macro expects signals named i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/lfpe_pkg.sv
// Package for the linear factor product expander.
// Holds the fixed field widths and the control bundle that drives the coefficient cells.
`timescale 1ns / 1ps

package lfpe_pkg;

    // Width of the a and b terms of one linear factor.
    localparam int FACTOR_WIDTH = 16;

    // Width of the power index on the result channel.
    localparam int POWER_WIDTH = 5;

    // Per-cycle commands broadcast to every coefficient cell.
    typedef struct packed {
        logic load;   // start a new product from the accepted factor
        logic mul;    // register both partial products
        logic add;    // sum the partial products into the coefficient
        logic shift;  // move coefficients one cell toward degree zero
    } t_cell_ctrl;

endpackage

>>> hw/rtl/lfpe_cell.sv
// One coefficient cell of the expander chain: holds c[k] and updates it.
// Depends on lfpe_pkg for the factor width and the cell control bundle.
`timescale 1ns / 1ps

module lfpe_cell import lfpe_pkg::*; #(
    parameter int COEFF_WIDTH = 48
) (
    input  logic                           i_clk,
    input  t_cell_ctrl                     i_ctrl,
    input  logic signed [FACTOR_WIDTH-1:0] i_b,
    input  logic signed [FACTOR_WIDTH-1:0] i_a,
    input  logic signed [COEFF_WIDTH-1:0]  i_load_value,
    input  logic signed [COEFF_WIDTH-1:0]  i_prev_coeff,
    input  logic signed [COEFF_WIDTH-1:0]  i_next_coeff,
    output logic signed [COEFF_WIDTH-1:0]  o_coeff,
    output logic                           o_wrap
);

    localparam int PROD_W = COEFF_WIDTH + FACTOR_WIDTH;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [COEFF_WIDTH-1:0] r_coeff;
    logic signed [PROD_W-1:0]      r_prod_own;
    logic signed [PROD_W-1:0]      r_prod_prev;
    logic signed [SUM_W-1:0]       w_sum;
    logic [SUM_W-COEFF_WIDTH:0]    w_upper;

    // Exact sum of c[k]*b and c[k-1]*a.
    assign w_sum   = SUM_W'(r_prod_own) + SUM_W'(r_prod_prev);
    assign w_upper = w_sum[SUM_W-1:COEFF_WIDTH-1];

    // The sum wrapped when its upper bits are not a plain sign extension.
    assign o_wrap  = i_ctrl.add && !((&w_upper) || (~|w_upper));
    assign o_coeff = r_coeff;

    // Partial products, registered before the add.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod_own  <= PROD_W'(r_coeff) * PROD_W'(i_b);
            r_prod_prev <= PROD_W'(i_prev_coeff) * PROD_W'(i_a);
        end
    end

    // Coefficient register: load, shift out toward degree zero, or accumulate.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_coeff <= i_load_value;
        end else if (i_ctrl.shift) begin
            r_coeff <= i_next_coeff;
        end else if (i_ctrl.add) begin
            r_coeff <= w_sum[COEFF_WIDTH-1:0];
        end
    end

endmodule

>>> hw/rtl/linear_factor_product_expander.sv
// Top level of the linear factor product expander: control, cell chain, result register.
// Depends on lfpe_pkg, lfpe_cell and assert_macros.svh.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------------
//  factor   | i_factor_valid / o_factor_ready | i_factor_constant, i_factor_slope,
//           |                                |   i_first_factor, i_last_factor
//  coeff    | o_coeff_valid / i_coeff_ready   | o_coefficient, o_power_index,
//           |                                |   o_final_coefficient, o_overflow_seen
//
// A factor that opens a product, or one dropped because the product is full, needs only the
// accept step. Other factors pass accept, multiply in every cell, then add in every cell.
// After a last factor the chain shifts out n+1 coefficients, one per cycle while the result
// register is free; a stalled result channel stalls the shift. Synchronous active-low reset
// clears the controller, the factor count, the overflow flag and the result valid.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module linear_factor_product_expander import lfpe_pkg::*; #(
    parameter int MAX_FACTORS = 16,
    parameter int COEFF_WIDTH = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_factor_valid,
    output logic                           o_factor_ready,
    input  logic signed [FACTOR_WIDTH-1:0] i_factor_constant,
    input  logic signed [FACTOR_WIDTH-1:0] i_factor_slope,
    input  logic                           i_first_factor,
    input  logic                           i_last_factor,
    output logic                           o_coeff_valid,
    input  logic                           i_coeff_ready,
    output logic signed [COEFF_WIDTH-1:0]  o_coefficient,
    output logic [POWER_WIDTH-1:0]         o_power_index,
    output logic                           o_final_coefficient,
    output logic                           o_overflow_seen
);

    localparam int NUM_CELLS = MAX_FACTORS + 1;
    localparam int CNT_W     = $clog2(MAX_FACTORS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [CNT_W-1:0]               r_fc;
    logic [CNT_W-1:0]               n_fc;
    logic                           r_overflow;
    logic                           n_overflow;
    logic [CNT_W-1:0]               r_emit_idx;
    logic [CNT_W-1:0]               n_emit_idx;
    logic                           r_last;
    logic signed [FACTOR_WIDTH-1:0] r_b;
    logic signed [FACTOR_WIDTH-1:0] r_a;

    logic                           r_out_valid;
    logic signed [COEFF_WIDTH-1:0]  r_out_coeff;
    logic [POWER_WIDTH-1:0]         r_out_power;
    logic                           r_out_final;
    logic                           r_out_ovf;

    logic                           w_accept;
    logic                           w_start;
    logic                           w_full;
    logic                           w_out_free;
    logic                           w_emit_load;
    logic                           w_emit_end;
    logic                           w_any_wrap;
    t_cell_ctrl                     w_ctrl;
    logic signed [COEFF_WIDTH-1:0]  w_load_b;
    logic signed [COEFF_WIDTH-1:0]  w_load_a;
    logic signed [COEFF_WIDTH-1:0]  w_coeff [NUM_CELLS];
    logic [NUM_CELLS-1:0]           w_wrap;

    // Handshake and decode of the accepted factor.
    assign o_factor_ready = (r_state == S_IDLE);
    assign w_accept       = i_factor_valid && o_factor_ready;
    assign w_start        = i_first_factor || (r_fc == '0);
    assign w_full         = (r_fc >= CNT_W'(MAX_FACTORS));
    assign w_out_free     = !r_out_valid || i_coeff_ready;
    assign w_emit_load    = (r_state == S_EMIT) && w_out_free;
    assign w_emit_end     = w_emit_load && (r_emit_idx == r_fc);
    assign w_any_wrap     = |w_wrap;

    // Commands broadcast to the cell chain.
    assign w_ctrl.load  = w_accept && w_start;
    assign w_ctrl.mul   = (r_state == S_MUL);
    assign w_ctrl.add   = (r_state == S_ADD);
    assign w_ctrl.shift = w_emit_load;

    // A new product loads c[0] = b and c[1] = a and clears the rest.
    assign w_load_b = COEFF_WIDTH'(i_factor_constant);
    assign w_load_a = COEFF_WIDTH'(i_factor_slope);

    // Chain of coefficient cells, c[0] at index 0.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        logic signed [COEFF_WIDTH-1:0] w_load_value;
        logic signed [COEFF_WIDTH-1:0] w_prev;
        logic signed [COEFF_WIDTH-1:0] w_next;

        if (k == 0) begin : g_low
            assign w_load_value = w_load_b;
            assign w_prev       = '0;
        end else if (k == 1) begin : g_one
            assign w_load_value = w_load_a;
            assign w_prev       = w_coeff[k-1];
        end else begin : g_high
            assign w_load_value = '0;
            assign w_prev       = w_coeff[k-1];
        end

        if (k == NUM_CELLS - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_coeff[k+1];
        end

        lfpe_cell #(
            .COEFF_WIDTH (COEFF_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_b          (r_b),
            .i_a          (r_a),
            .i_load_value (w_load_value),
            .i_prev_coeff (w_prev),
            .i_next_coeff (w_next),
            .o_coeff      (w_coeff[k]),
            .o_wrap       (w_wrap[k])
        );
    end

    // Controller next-state logic.
    always_comb begin
        n_state    = r_state;
        n_fc       = r_fc;
        n_overflow = r_overflow;
        n_emit_idx = r_emit_idx;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_emit_idx = '0;
                    if (w_start) begin
                        n_fc       = CNT_W'(1);
                        n_overflow = 1'b0;
                        n_state    = i_last_factor ? S_EMIT : S_IDLE;
                    end else if (w_full) begin
                        n_overflow = 1'b1;
                        n_state    = i_last_factor ? S_EMIT : S_IDLE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_fc       = r_fc + CNT_W'(1);
                n_overflow = r_overflow || w_any_wrap;
                n_state    = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_emit_end) begin
                    n_fc    = '0;
                    n_state = S_IDLE;
                end else if (w_emit_load) begin
                    n_emit_idx = r_emit_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fc       <= '0;
            r_overflow <= 1'b0;
            r_emit_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_fc       <= n_fc;
            r_overflow <= n_overflow;
            r_emit_idx <= n_emit_idx;
        end
    end

    // Factor terms held for the multiply step.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b    <= i_factor_constant;
            r_a    <= i_factor_slope;
            r_last <= i_last_factor;
        end
    end

    // Result register: takes c[0] of the chain as the chain shifts down.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_coeff_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_load) begin
            r_out_coeff <= w_coeff[0];
            r_out_power <= POWER_WIDTH'(r_emit_idx);
            r_out_final <= (r_emit_idx == r_fc);
            r_out_ovf   <= r_overflow;
        end
    end

    assign o_coeff_valid       = r_out_valid;
    assign o_coefficient       = r_out_coeff;
    assign o_power_index       = r_out_power;
    assign o_final_coefficient = r_out_final;
    assign o_overflow_seen     = r_out_ovf;

    // Checks on the controller.
    `ASSERT_IMPL(a_fc_in_range, 1'b1, r_fc <= CNT_W'(MAX_FACTORS))
    `ASSERT_IMPL(a_emit_idx_bound, r_state == S_EMIT, r_emit_idx <= r_fc)
    `ASSERT_NEXT(a_mul_then_add, r_state == S_MUL, r_state == S_ADD)
    `ASSERT_NEXT(a_emit_closes, w_emit_end, (r_fc == '0) && (r_state == S_IDLE))
    `ASSERT_NEXT(a_drop_sets_ovf, w_accept && !w_start && w_full, r_overflow)

endmodule

>>> test/tb_linear_factor_product_expander.sv
// Self-checking testbench for linear_factor_product_expander.
// Drives factor transactions, predicts the expanded coefficients and checks every result.
// Depends on lfpe_pkg and the linear_factor_product_expander RTL.
`timescale 1ns / 1ps

module tb_linear_factor_product_expander;
    import lfpe_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int MAX_FACTORS = 16;
    localparam int COEFF_WIDTH = 48;
    // Wide enough for c*b + d*a without any loss.
    localparam int PROD_WIDTH  = COEFF_WIDTH + FACTOR_WIDTH + 2;
    localparam int RESET_CYCLES = 11;
    localparam int END_SLACK   = 40;
    localparam int STALL_LIMIT = 4000;

    // One expanded coefficient as it should leave the block.
    typedef struct packed {
        logic signed [COEFF_WIDTH-1:0] coefficient;
        logic [POWER_WIDTH-1:0]        power;
        logic                          is_top;
        logic                          overflow;
    } t_coeff_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_factor_valid;
    logic                           o_factor_ready;
    logic signed [FACTOR_WIDTH-1:0] i_factor_constant;
    logic signed [FACTOR_WIDTH-1:0] i_factor_slope;
    logic                           i_first_factor;
    logic                           i_last_factor;
    logic                           o_coeff_valid;
    logic                           i_coeff_ready;
    logic signed [COEFF_WIDTH-1:0]  o_coefficient;
    logic [POWER_WIDTH-1:0]         o_power_index;
    logic                           o_final_coefficient;
    logic                           o_overflow_seen;

    // Predicted polynomial, mirrored from the accepted factors.
    logic signed [COEFF_WIDTH-1:0] poly_coeff [0:MAX_FACTORS];
    int                            poly_degree;
    logic                          poly_wrapped;

    t_coeff_result expected_coeffs [$];
    int            error_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            stall_cycles;

    linear_factor_product_expander #(
        .MAX_FACTORS(MAX_FACTORS),
        .COEFF_WIDTH(COEFF_WIDTH)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_factor_valid     (i_factor_valid),
        .o_factor_ready     (o_factor_ready),
        .i_factor_constant  (i_factor_constant),
        .i_factor_slope     (i_factor_slope),
        .i_first_factor     (i_first_factor),
        .i_last_factor      (i_last_factor),
        .o_coeff_valid      (o_coeff_valid),
        .i_coeff_ready      (i_coeff_ready),
        .o_coefficient      (o_coefficient),
        .o_power_index      (o_power_index),
        .o_final_coefficient(o_final_coefficient),
        .o_overflow_seen    (o_overflow_seen)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Exact c*b + d*a before any wrapping.
    function automatic logic signed [PROD_WIDTH-1:0] mac_exact(
        input logic signed [COEFF_WIDTH-1:0]  c,
        input logic signed [FACTOR_WIDTH-1:0] b,
        input logic signed [COEFF_WIDTH-1:0]  d,
        input logic signed [FACTOR_WIDTH-1:0] a
    );
        logic signed [PROD_WIDTH-1:0] wc, wb, wd, wa;
        wc = PROD_WIDTH'(c);
        wb = PROD_WIDTH'(b);
        wd = PROD_WIDTH'(d);
        wa = PROD_WIDTH'(a);
        return wc * wb + wd * wa;
    endfunction

    // True when the exact sum does not survive truncation to the coefficient width.
    function automatic logic wraps_coeff(input logic signed [PROD_WIDTH-1:0] sum);
        logic signed [COEFF_WIDTH-1:0] low;
        logic signed [PROD_WIDTH-1:0]  back;
        low  = sum[COEFF_WIDTH-1:0];
        back = PROD_WIDTH'(low);
        return back != sum;
    endfunction

    // Applies one accepted factor to the predicted polynomial and queues any results.
    task automatic expand_factor(
        input logic signed [FACTOR_WIDTH-1:0] b,
        input logic signed [FACTOR_WIDTH-1:0] a,
        input logic                           is_first,
        input logic                           is_last
    );
        logic signed [PROD_WIDTH-1:0] sum;
        t_coeff_result                res;
        if (is_first || poly_degree == 0) begin
            // A new product; also taken when nothing is open.
            for (int k = 0; k <= MAX_FACTORS; k++) poly_coeff[k] = '0;
            poly_coeff[0] = COEFF_WIDTH'(b);
            poly_coeff[1] = COEFF_WIDTH'(a);
            poly_degree   = 1;
            poly_wrapped  = 1'b0;
        end else if (poly_degree >= MAX_FACTORS) begin
            // No room for another factor: it is dropped and flagged.
            poly_wrapped = 1'b1;
        end else begin
            // Highest degree first so each term still sees the old lower coefficient.
            for (int k = poly_degree + 1; k >= 1; k--) begin
                sum = mac_exact(poly_coeff[k], b, poly_coeff[k-1], a);
                if (wraps_coeff(sum)) poly_wrapped = 1'b1;
                poly_coeff[k] = sum[COEFF_WIDTH-1:0];
            end
            sum = mac_exact(poly_coeff[0], b, '0, '0);
            if (wraps_coeff(sum)) poly_wrapped = 1'b1;
            poly_coeff[0] = sum[COEFF_WIDTH-1:0];
            poly_degree++;
        end
        if (is_last) begin
            for (int k = 0; k <= poly_degree; k++) begin
                res.coefficient = poly_coeff[k];
                res.power       = POWER_WIDTH'(k);
                res.is_top      = (k == poly_degree);
                res.overflow    = poly_wrapped;
                expected_coeffs.push_back(res);
            end
            poly_degree = 0;
        end
    endtask

    // Sends one factor transaction, with random idle cycles ahead of it.
    task automatic send_factor(
        input logic signed [FACTOR_WIDTH-1:0] b,
        input logic signed [FACTOR_WIDTH-1:0] a,
        input logic                           is_first,
        input logic                           is_last
    );
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_factor_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_factor_valid    <= 1'b1;
        i_factor_constant <= b;
        i_factor_slope    <= a;
        i_first_factor    <= is_first;
        i_last_factor     <= is_last;
        do @(posedge i_clk); while (!o_factor_ready);
        expand_factor(b, a, is_first, is_last);
    endtask

    // Holds off the sender until every predicted coefficient has been received.
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_factor_valid <= 1'b0;
        while (expected_coeffs.size() != 0) @(posedge i_clk);
    endtask

    // Random factor term: now and then an extreme, else tiny or, when asked, full range.
    function automatic logic signed [FACTOR_WIDTH-1:0] pick_term(input bit full_range);
        int v;
        case ($urandom_range(9))
            0: v = -32768;
            1: v = 32767;
            default: v = full_range ? int'($urandom) : int'($urandom_range(8)) - 4;
        endcase
        return v[FACTOR_WIDTH-1:0];
    endfunction

    // One-factor products built from the extremes of both terms, from zero and from minus one.
    task automatic test_single_factor_extremes();
        send_factor(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
        send_factor(16'sd32767, -16'sd32768, 1'b1, 1'b1);
        send_factor(16'sd0, 16'sd0, 1'b1, 1'b1);
        send_factor(-16'sd1, -16'sd1, 1'b1, 1'b1);
    endtask

    // A factor without the first flag while no product is open starts one anyway.
    task automatic test_no_open_product();
        send_factor(16'sd3, 16'sd2, 1'b0, 1'b0);
        send_factor(16'sd5, -16'sd1, 1'b0, 1'b1);
    endtask

    // A first flag in the middle of a product discards what was held.
    task automatic test_restart_mid_product();
        send_factor(16'sd1, 16'sd1, 1'b1, 1'b0);
        send_factor(16'sd2, 16'sd3, 1'b0, 1'b0);
        send_factor(16'sd7, -16'sd2, 1'b1, 1'b0);
        send_factor(-16'sd4, 16'sd5, 1'b0, 1'b1);
    endtask

    // Four factors of the most negative value wrap; the next product starts clean.
    task automatic test_coefficient_wrap();
        for (int i = 0; i < 4; i++) send_factor(-16'sd32768, -16'sd32768, i == 0, i == 3);
        send_factor(16'sd2, 16'sd1, 1'b1, 1'b1);
    endtask

    // The sender waits for all results, both after a product and in the middle of one.
    task automatic test_pause_until_drained();
        send_factor(16'sd2, -16'sd3, 1'b1, 1'b0);
        send_factor(16'sd1, 16'sd1, 1'b0, 1'b1);
        pause_until_drained();
        send_factor(-16'sd5, 16'sd7, 1'b1, 1'b1);
        send_factor(16'sd3, 16'sd1, 1'b1, 1'b0);
        pause_until_drained();
        send_factor(16'sd1, -16'sd1, 1'b0, 1'b1);
    endtask

    // Products of the maximum length, and ones with factors beyond it.
    task automatic test_full_products();
        int len;
        for (int p = 0; p < 3; p++) begin
            len = MAX_FACTORS + p;
            for (int i = 0; i < len; i++) begin
                send_factor(pick_term(i == 5), pick_term(1'b0), i == 0, i == len - 1);
            end
        end
    endtask

    // Mostly well-formed products with random content, the rest random flag noise.
    task automatic test_random_products(input int item_count);
        int  sent;
        int  len;
        bit  full_range;
        sent = 0;
        while (sent < item_count) begin
            if ($urandom_range(99) < 80) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_FACTORS)
                                               : $urandom_range(1, 5);
                full_range = 1'($urandom_range(1));
                for (int i = 0; i < len; i++) begin
                    send_factor(pick_term(full_range), pick_term(full_range),
                                i == 0, i == len - 1);
                end
                sent += len;
            end else begin
                send_factor(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // Compares one field of a received coefficient transaction.
    task automatic check_field(input string label, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, label, expected, actual);
            error_count++;
        end
    endtask

    // The receiver idles at random, at the falling edge like every other input.
    always @(negedge i_clk) begin
        i_coeff_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each accepted coefficient transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_coeff_result exp_res;
        if (i_rst_n && o_coeff_valid && i_coeff_ready) begin
            if (expected_coeffs.size() == 0) begin
                $display("%0t: unexpected coefficient %0h at power %0d",
                         $time, o_coefficient, o_power_index);
                error_count++;
            end else begin
                exp_res = expected_coeffs.pop_front();
                check_field("coefficient", 64'(unsigned'(exp_res.coefficient)),
                            64'(unsigned'(o_coefficient)));
                check_field("power_index", 64'(exp_res.power), 64'(o_power_index));
                check_field("final_coefficient", 64'(exp_res.is_top),
                            64'(o_final_coefficient));
                check_field("overflow_seen", 64'(exp_res.overflow), 64'(o_overflow_seen));
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_factor_valid && o_factor_ready) || (o_coeff_valid && i_coeff_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout with %0d coefficients outstanding",
                     $time, expected_coeffs.size());
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_factor_valid    = 1'b0;
        i_factor_constant = '0;
        i_factor_slope    = '0;
        i_first_factor    = 1'b0;
        i_last_factor     = 1'b0;
        i_coeff_ready     = 1'b0;
        error_count       = 0;
        stall_cycles      = 0;
        poly_degree       = 0;
        poly_wrapped      = 1'b0;
        for (int k = 0; k <= MAX_FACTORS; k++) poly_coeff[k] = '0;

        // Light sender idling against a slow receiver.
        send_idle_pct = 16;
        recv_idle_pct = 49;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_factor_extremes();
        test_no_open_product();
        test_restart_mid_product();
        test_coefficient_wrap();
        test_pause_until_drained();

        // Slow sender against a mostly ready receiver.
        send_idle_pct = 49;
        recv_idle_pct = 16;
        test_full_products();
        test_random_products(50);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_products(55);

        pause_until_drained();
        repeat (END_SLACK) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lfpe_pkg.sv
hw/rtl/lfpe_cell.sv
hw/rtl/linear_factor_product_expander.sv
test/tb_linear_factor_product_expander.sv
